// ===== hdl/button_autorepeat_events_unit_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef BUTTON_AUTOREPEAT_EVENTS_UNIT_MACROS_SVH
`define BUTTON_AUTOREPEAT_EVENTS_UNIT_MACROS_SVH

// same-cycle implication
`define BAE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/bae_pkg.sv =====
package bae_pkg;

    localparam int NUM_BUTTONS_DEF = 22;
    localparam int TIME_W          = 63;
    localparam int SUM_W           = TIME_W + 1;
    localparam int DELAY_W         = 24;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 63;

    localparam logic [DELAY_W-1:0] LONG_PRESS_RST  = DELAY_W'(400000);
    localparam logic [DELAY_W-1:0] REPEAT_RST      = DELAY_W'(60000);
    localparam logic [DELAY_W-1:0] MUTE_WINDOW_RST = DELAY_W'(1000000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS  = 3'd0,
        CFG_REPEAT      = 3'd1,
        CFG_MUTE_WINDOW = 3'd2,
        CFG_MUTE_MASK   = 3'd3,
        CFG_OPEN_TIME   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [DELAY_W-1:0] long_press_delay;
        logic [DELAY_W-1:0] repeat_delay;
        logic [DELAY_W-1:0] mute_window;
        logic [TIME_W-1:0]  open_time;
    } t_cfg;

    // exact 64-bit form of base + delay, never wraps
    function automatic logic [SUM_W-1:0] stamp_plus(input logic [TIME_W-1:0] base,
                                                    input logic [DELAY_W-1:0] delay);
        stamp_plus = {1'b0, base} + {{(SUM_W-DELAY_W){1'b0}}, delay};
    endfunction

    // true when now is strictly past base + delay
    function automatic logic time_past(input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] base,
                                       input logic [DELAY_W-1:0] delay);
        time_past = {1'b0, now} > stamp_plus(base, delay);
    endfunction

endpackage

// ===== hdl/bae_poll_if.sv =====
interface bae_poll_if #(
    parameter int NUM_BUTTONS = bae_pkg::NUM_BUTTONS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [NUM_BUTTONS-1:0]      button_mask;
    logic [bae_pkg::TIME_W-1:0]  now_time;

    modport source (output valid, output button_mask, output now_time, input ready);
    modport sink   (input valid, input button_mask, input now_time, output ready);
endinterface

// ===== hdl/bae_event_if.sv =====
interface bae_event_if #(
    parameter int NUM_BUTTONS = bae_pkg::NUM_BUTTONS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [NUM_BUTTONS-1:0] press_events;
    logic [NUM_BUTTONS-1:0] repeat_events;

    modport source (output valid, output press_events, output repeat_events, input ready);
    modport sink   (input valid, input press_events, input repeat_events, output ready);
endinterface

// ===== hdl/bae_cfg_if.sv =====
interface bae_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bae_pkg::CFG_IDX_W-1:0]   index;
    logic [bae_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/bae_cfg_regs.sv =====
module bae_cfg_regs #(
    parameter int NUM_BUTTONS = bae_pkg::NUM_BUTTONS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    bae_cfg_if.sink                i_cfg,
    output bae_pkg::t_cfg          o_cfg,
    output logic [NUM_BUTTONS-1:0] o_mute_mask
);

    bae_pkg::t_cfg          r_cfg;
    logic [NUM_BUTTONS-1:0] r_mute_mask;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_delay <= bae_pkg::LONG_PRESS_RST;
            r_cfg.repeat_delay     <= bae_pkg::REPEAT_RST;
            r_cfg.mute_window      <= bae_pkg::MUTE_WINDOW_RST;
            r_cfg.open_time        <= '0;
            r_mute_mask            <= '0;
        end else if (i_cfg.valid) begin
            case (bae_pkg::t_cfg_idx'(i_cfg.index))
                bae_pkg::CFG_LONG_PRESS: begin
                    r_cfg.long_press_delay <= i_cfg.data[bae_pkg::DELAY_W-1:0];
                end
                bae_pkg::CFG_REPEAT: begin
                    r_cfg.repeat_delay <= i_cfg.data[bae_pkg::DELAY_W-1:0];
                end
                bae_pkg::CFG_MUTE_WINDOW: begin
                    r_cfg.mute_window <= i_cfg.data[bae_pkg::DELAY_W-1:0];
                end
                bae_pkg::CFG_MUTE_MASK: begin
                    r_mute_mask <= i_cfg.data[NUM_BUTTONS-1:0];
                end
                bae_pkg::CFG_OPEN_TIME: begin
                    r_cfg.open_time <= i_cfg.data[bae_pkg::TIME_W-1:0];
                end
                default: begin
                    // unknown index: dropped
                end
            endcase
        end
    end

    assign o_cfg       = r_cfg;
    assign o_mute_mask = r_mute_mask;

endmodule

// ===== hdl/bae_front.sv =====
module bae_front #(
    parameter int NUM_BUTTONS = bae_pkg::NUM_BUTTONS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bae_poll_if.sink                    i_poll,
    input  bae_pkg::t_cfg               i_cfg,
    input  logic [NUM_BUTTONS-1:0]      i_mute_mask,
    input  logic                        i_advance,
    output logic                        o_valid,
    output logic [NUM_BUTTONS-1:0]      o_buttons,
    output logic [bae_pkg::TIME_W-1:0]  o_now
);

    logic                        r_valid;
    logic [NUM_BUTTONS-1:0]      r_buttons;
    logic [bae_pkg::TIME_W-1:0]  r_now;
    logic                        w_accept;
    logic                        w_muted;
    logic [NUM_BUTTONS-1:0]      n_buttons;

    assign i_poll.ready = !r_valid || i_advance;
    assign w_accept     = i_poll.valid && i_poll.ready;

    // mute while open_time + mute_window > now
    assign w_muted   = bae_pkg::stamp_plus(i_cfg.open_time, i_cfg.mute_window) >
                       {1'b0, i_poll.now_time};
    assign n_buttons = w_muted ? (i_poll.button_mask & ~i_mute_mask) : i_poll.button_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_buttons <= n_buttons;
            r_now     <= i_poll.now_time;
        end
    end

    assign o_valid   = r_valid;
    assign o_buttons = r_buttons;
    assign o_now     = r_now;

endmodule

// ===== hdl/bae_lane.sv =====
`include "button_autorepeat_events_unit_macros.svh"

module bae_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_pressed,
    input  logic [bae_pkg::TIME_W-1:0]  i_now,
    input  bae_pkg::t_cfg               i_cfg,
    output logic                        o_press,
    output logic                        o_repeat
);

    logic                        r_held;
    logic                        r_repeating;
    logic [bae_pkg::TIME_W-1:0]  r_press_stamp;
    logic [bae_pkg::TIME_W-1:0]  r_repeat_stamp;
    logic                        n_held;
    logic                        n_repeating;
    logic [bae_pkg::TIME_W-1:0]  n_press_stamp;
    logic [bae_pkg::TIME_W-1:0]  n_repeat_stamp;

    always_comb begin
        n_held         = r_held;
        n_repeating    = r_repeating;
        n_press_stamp  = r_press_stamp;
        n_repeat_stamp = r_repeat_stamp;
        o_press        = 1'b0;
        o_repeat       = 1'b0;
        if (i_pressed) begin
            if (!r_held) begin
                n_held        = 1'b1;
                n_press_stamp = i_now;
                o_press       = 1'b1;
            end else if (r_repeating) begin
                if (bae_pkg::time_past(i_now, r_repeat_stamp, i_cfg.repeat_delay)) begin
                    n_repeat_stamp = i_now;
                    o_repeat       = 1'b1;
                end
            end else if (bae_pkg::time_past(i_now, r_press_stamp, i_cfg.long_press_delay)) begin
                // enter repeat mode silently, counting from the press
                n_repeating    = 1'b1;
                n_repeat_stamp = r_press_stamp;
            end
        end else begin
            n_held      = 1'b0;
            n_repeating = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= 1'b0;
            r_repeating <= 1'b0;
        end else if (i_step) begin
            r_held      <= n_held;
            r_repeating <= n_repeating;
        end
    end

    // stamps are only read while the flags say they were written
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_press_stamp  <= n_press_stamp;
            r_repeat_stamp <= n_repeat_stamp;
        end
    end

    `BAE_ASSERT_IMPL(a_repeat_needs_held, i_clk, i_rst_n, r_repeating, r_held)
    `BAE_ASSERT_NEXT(a_press_sets_held, i_clk, i_rst_n, i_step && o_press,
                     r_held && !r_repeating)
    `BAE_ASSERT_NEXT(a_release_clears, i_clk, i_rst_n, i_step && !i_pressed,
                     !r_held && !r_repeating)

endmodule

// ===== hdl/button_autorepeat_events_unit.sv =====
// Channel   Dir  Transfer when        Payload
// i_poll    in   valid && ready       button_mask, now_time
// o_event   out  valid && ready       press_events, repeat_events
// i_cfg     in   valid && ready       index, data (ready always high)
//
// One poll per cycle sustained while o_event.ready stays high.
// Poll register (mute applied on entry) feeds per-button lanes, result lands in an
// output register; the lane state updates in the same cycle the result is loaded.
// Synchronous active-low reset clears flags and valids; config returns to defaults.
// A stalled result holds; the poll register still takes a new poll once the
// result moves on.
`include "button_autorepeat_events_unit_macros.svh"

module button_autorepeat_events_unit #(
    parameter int NUM_BUTTONS = bae_pkg::NUM_BUTTONS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bae_poll_if.sink      i_poll,
    bae_event_if.source   o_event,
    bae_cfg_if.sink       i_cfg
);

    bae_pkg::t_cfg               w_cfg;
    logic [NUM_BUTTONS-1:0]      w_mute_mask;
    logic                        w_front_valid;
    logic [NUM_BUTTONS-1:0]      w_buttons;
    logic [bae_pkg::TIME_W-1:0]  w_now;
    logic                        w_advance;
    logic [NUM_BUTTONS-1:0]      w_press;
    logic [NUM_BUTTONS-1:0]      w_repeat;
    logic                        r_out_valid;
    logic [NUM_BUTTONS-1:0]      r_press;
    logic [NUM_BUTTONS-1:0]      r_repeat;

    bae_cfg_regs #(.NUM_BUTTONS(NUM_BUTTONS)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .o_cfg       (w_cfg),
        .o_mute_mask (w_mute_mask)
    );

    bae_front #(.NUM_BUTTONS(NUM_BUTTONS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_poll      (i_poll),
        .i_cfg       (w_cfg),
        .i_mute_mask (w_mute_mask),
        .i_advance   (w_advance),
        .o_valid     (w_front_valid),
        .o_buttons   (w_buttons),
        .o_now       (w_now)
    );

    assign w_advance = w_front_valid && (!r_out_valid || o_event.ready);

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        bae_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_step    (w_advance),
            .i_pressed (w_buttons[g]),
            .i_now     (w_now),
            .i_cfg     (w_cfg),
            .o_press   (w_press[g]),
            .o_repeat  (w_repeat[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_press  <= w_press;
            r_repeat <= w_repeat;
        end
    end

    assign o_event.valid         = r_out_valid;
    assign o_event.press_events  = r_press;
    assign o_event.repeat_events = r_repeat;

    `BAE_ASSERT_IMPL(a_events_disjoint, i_clk, i_rst_n, r_out_valid,
                     (r_press & r_repeat) == '0)
    `BAE_ASSERT_IMPL(a_stall_means_full, i_clk, i_rst_n, !i_poll.ready, w_front_valid)
    `BAE_ASSERT_NEXT(a_advance_loads_out, i_clk, i_rst_n, w_advance, r_out_valid)

endmodule

// ===== tb/tb_button_autorepeat_events_unit.sv =====
module tb_button_autorepeat_events_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NB             = bae_pkg::NUM_BUTTONS_DEF;
    localparam int          IDLE_PCT       = 21;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [62:0] STAMP_MAX      = {bae_pkg::TIME_W{1'b1}};
    localparam logic [NB-1:0] ALL_BUTTONS  = {NB{1'b1}};

    typedef struct packed {
        logic [NB-1:0] press_events;
        logic [NB-1:0] rpt_events;
    } t_evt;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bae_poll_if  poll_if ();
    bae_event_if evt_if ();
    bae_cfg_if   cfg_if ();

    button_autorepeat_events_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_poll  (poll_if),
        .o_event (evt_if),
        .i_cfg   (cfg_if)
    );

    always #4 i_clk = ~i_clk;

    // predictor copy of registers and per-button state
    logic [bae_pkg::DELAY_W-1:0] hold_gap   = bae_pkg::LONG_PRESS_RST;
    logic [bae_pkg::DELAY_W-1:0] rep_gap    = bae_pkg::REPEAT_RST;
    logic [bae_pkg::DELAY_W-1:0] mute_len   = bae_pkg::MUTE_WINDOW_RST;
    logic [NB-1:0]      mute_btns  = '0;
    logic [62:0]        open_at    = '0;
    logic [NB-1:0]      is_held    = '0;
    logic [NB-1:0]      is_repeating = '0;
    logic [62:0]        pressed_at  [NB];
    logic [62:0]        last_rep_at [NB];

    t_evt expected_events_q[$];
    int   mismatches  = 0;
    int   idle_cycles = 0;
    bit   idle_on     = 1'b1;

    function automatic logic [62:0] rand_stamp();
        return 63'({$urandom(), $urandom()});
    endfunction

    function automatic logic [NB-1:0] rand_buttons();
        return NB'($urandom());
    endfunction

    function automatic t_evt predict_events(input logic [NB-1:0] mask, input logic [62:0] now);
        logic [NB-1:0] live;
        logic [63:0]   now64;
        t_evt          ev;
        int            b;
        now64 = {1'b0, now};
        live  = mask;
        ev    = '0;
        // sums are 64 bits wide so nothing wraps
        if ({1'b0, open_at} + {40'd0, mute_len} > now64)
            live &= ~mute_btns;
        for (b = 0; b < NB; b++) begin
            if (live[b]) begin
                if (!is_held[b]) begin
                    is_held[b]         = 1'b1;
                    pressed_at[b]      = now;
                    ev.press_events[b] = 1'b1;
                end else if (is_repeating[b]) begin
                    if (now64 > {1'b0, last_rep_at[b]} + {40'd0, rep_gap}) begin
                        last_rep_at[b]   = now;
                        ev.rpt_events[b] = 1'b1;
                    end
                end else if (now64 > {1'b0, pressed_at[b]} + {40'd0, hold_gap}) begin
                    is_repeating[b] = 1'b1;
                    last_rep_at[b]  = pressed_at[b];
                end
            end else begin
                is_held[b]      = 1'b0;
                is_repeating[b] = 1'b0;
            end
        end
        return ev;
    endfunction

    function automatic void apply_register(input bae_pkg::t_cfg_idx idx,
                                           input logic [62:0] data);
        case (idx)
            bae_pkg::CFG_LONG_PRESS:  hold_gap  = data[bae_pkg::DELAY_W-1:0];
            bae_pkg::CFG_REPEAT:      rep_gap   = data[bae_pkg::DELAY_W-1:0];
            bae_pkg::CFG_MUTE_WINDOW: mute_len  = data[bae_pkg::DELAY_W-1:0];
            bae_pkg::CFG_MUTE_MASK:   mute_btns = data[NB-1:0];
            bae_pkg::CFG_OPEN_TIME:   open_at   = data;
            default: ;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h actual %h", what, want, got);
    endtask

    // called at a falling edge, returns at a falling edge; valid stays up
    task automatic send_poll(input logic [NB-1:0] mask, input logic [62:0] now);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            poll_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        poll_if.valid       <= 1'b1;
        poll_if.button_mask <= mask;
        poll_if.now_time    <= now;
        do @(posedge i_clk); while (!poll_if.ready);
        expected_events_q.push_back(predict_events(mask, now));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        while (expected_events_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic finish_polls();
        poll_if.valid <= 1'b0;
        wait_idle();
    endtask

    task automatic write_register(input bae_pkg::t_cfg_idx idx, input logic [62:0] data);
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        apply_register(idx, data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // junk above each field's width must be dropped by the block
    task automatic set_config(input logic [bae_pkg::DELAY_W-1:0] hold,
                              input logic [bae_pkg::DELAY_W-1:0] rep,
                              input logic [bae_pkg::DELAY_W-1:0] mlen,
                              input logic [NB-1:0] mbtn,
                              input logic [62:0] opened);
        logic [62:0] junk;
        junk = rand_stamp();
        write_register(bae_pkg::CFG_LONG_PRESS, {junk[62:bae_pkg::DELAY_W], hold});
        junk = rand_stamp();
        write_register(bae_pkg::CFG_REPEAT, {junk[62:bae_pkg::DELAY_W], rep});
        junk = rand_stamp();
        write_register(bae_pkg::CFG_MUTE_WINDOW, {junk[62:bae_pkg::DELAY_W], mlen});
        junk = rand_stamp();
        write_register(bae_pkg::CFG_MUTE_MASK, {junk[62:NB], mbtn});
        write_register(bae_pkg::CFG_OPEN_TIME, opened);
    endtask

    // held buttons drift a few bits per poll, time mostly moves forward
    task automatic run_polls(input logic [62:0] start, input int count, input int noise_pct);
        logic [62:0]   t;
        logic [NB-1:0] held;
        logic [31:0]   step;
        t    = start;
        held = rand_buttons();
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < noise_pct) begin
                send_poll(rand_buttons(), rand_stamp());
            end else begin
                held ^= rand_buttons() & rand_buttons() & rand_buttons();
                case ($urandom_range(3))
                    0: step = $urandom_range(rep_gap + 2);
                    1: step = $urandom_range(hold_gap + rep_gap + 2);
                    2: step = $urandom_range(3);
                    default: step = $urandom_range(1 << 24);
                endcase
                t += 63'(step);
                send_poll(held, t);
            end
        end
        finish_polls();
    endtask

    task automatic test_reset_defaults();
        send_poll('0, '0);
        send_poll(ALL_BUTTONS, '0);
        send_poll(ALL_BUTTONS, 63'd400000);   // exactly at the hold limit
        send_poll(ALL_BUTTONS, 63'd400001);   // enters repeat mode, silent
        send_poll(ALL_BUTTONS, 63'd460001);
        send_poll(ALL_BUTTONS, 63'd520001);   // exactly at the repeat gap
        send_poll(ALL_BUTTONS, 63'd520002);
        send_poll(ALL_BUTTONS, 63'd10);       // time runs backwards
        send_poll(22'h155555, 63'd520003);
        send_poll(ALL_BUTTONS, 63'd520004);
        send_poll('0, STAMP_MAX);
        send_poll(ALL_BUTTONS, STAMP_MAX);
        send_poll(ALL_BUTTONS, STAMP_MAX);
        send_poll(22'h000001, '0);
        send_poll(22'h200000, 63'd1);
        send_poll('0, 63'd2);
        finish_polls();
    endtask

    task automatic test_mute_window();
        logic [62:0]                 opened;
        logic [bae_pkg::DELAY_W-1:0] mlen;
        opened = rand_stamp() & 63'h3FFF_FFFF_FFFF_FFFF;
        mlen   = bae_pkg::DELAY_W'($urandom_range(24'hFFFFFF, 2));
        set_config(24'd100, 24'd50, mlen, 22'h2AAAAA, opened);
        send_poll(ALL_BUTTONS, opened - 1);          // before open: still muted
        send_poll(ALL_BUTTONS, opened + mlen - 1);   // last muted stamp
        send_poll(ALL_BUTTONS, opened + mlen);       // window closed
        send_poll(ALL_BUTTONS, opened + mlen + 200);
        send_poll(ALL_BUTTONS, opened);              // muted again, releases muted lanes
        send_poll('0, opened + mlen + 1);
        send_poll(ALL_BUTTONS, opened + mlen + 1);
        finish_polls();
        set_config(24'd100, 24'd50, mlen, ALL_BUTTONS, opened);
        send_poll(ALL_BUTTONS, opened + 1);
        send_poll(ALL_BUTTONS, opened + mlen);
        send_poll('0, opened + mlen + 1);
        finish_polls();
    endtask

    task automatic test_config_extremes();
        set_config('0, '0, '0, '0, '0);
        run_polls(rand_stamp(), 80, 15);
        // open_time plus window exceeds 63 bits: always muted
        set_config({bae_pkg::DELAY_W{1'b1}}, {bae_pkg::DELAY_W{1'b1}},
                   {bae_pkg::DELAY_W{1'b1}}, ALL_BUTTONS, STAMP_MAX);
        run_polls(STAMP_MAX - 63'($urandom_range(1 << 20)), 40, 15);
        set_config({bae_pkg::DELAY_W{1'b1}}, {bae_pkg::DELAY_W{1'b1}}, '0, '0, '0);
        run_polls(rand_stamp(), 120, 10);
    endtask

    task automatic test_unmapped_registers();
        set_config(24'd300, 24'd40, '0, '0, '0);
        for (int k = 1; k <= 3; k++)
            write_register(bae_pkg::t_cfg_idx'(int'(bae_pkg::CFG_OPEN_TIME) + k),
                           rand_stamp());
        run_polls(rand_stamp(), 40, 10);
    endtask

    task automatic test_random_polls();
        logic [62:0]                 start;
        logic [bae_pkg::DELAY_W-1:0] mlen;
        for (int phase = 0; phase < 6; phase++) begin
            start = rand_stamp();
            if ($urandom_range(7) == 0)
                start = STAMP_MAX - 63'($urandom_range(1 << 22));
            mlen = bae_pkg::DELAY_W'($urandom_range(5000));
            set_config(bae_pkg::DELAY_W'($urandom_range(3000)),
                       bae_pkg::DELAY_W'($urandom_range(800)), mlen,
                       rand_buttons(), start + 63'($urandom_range(mlen)));
            run_polls(start, 220, 15);
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        set_config(bae_pkg::DELAY_W'($urandom_range(1000)),
                   bae_pkg::DELAY_W'($urandom_range(300)),
                   24'd2000, rand_buttons(), '0);
        run_polls(63'($urandom_range(1000)), 300, 10);
        idle_on = 1'b1;
    endtask

    always @(negedge i_clk)
        evt_if.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge i_clk) begin : check_results
        t_evt got;
        t_evt want;
        if (i_rst_n && evt_if.valid && evt_if.ready) begin
            got = '{press_events: evt_if.press_events, rpt_events: evt_if.repeat_events};
            if (expected_events_q.size() == 0) begin
                note_mismatch("unexpected result", '0, 64'(got));
            end else begin
                want = expected_events_q.pop_front();
                if (got.press_events !== want.press_events)
                    note_mismatch("press_events", 64'(want.press_events),
                                  64'(got.press_events));
                if (got.rpt_events !== want.rpt_events)
                    note_mismatch("repeat_events", 64'(want.rpt_events),
                                  64'(got.rpt_events));
            end
        end
    end

    // counts cycles without any transfer on any channel
    always @(posedge i_clk) begin
        if ((poll_if.valid && poll_if.ready) || (evt_if.valid && evt_if.ready)
                || (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("button_autorepeat_events_unit verification failed");
            $finish;
        end
    end

    initial begin
        for (int b = 0; b < NB; b++) begin
            pressed_at[b]  = '0;
            last_rep_at[b] = '0;
        end
        i_rst_n             = 1'b0;
        poll_if.valid       = 1'b0;
        poll_if.button_mask = '0;
        poll_if.now_time    = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_mute_window();
        test_config_extremes();
        test_unmapped_registers();
        test_random_polls();
        test_back_to_back();

        finish_polls();
        if (mismatches == 0 && expected_events_q.size() == 0)
            $display("button_autorepeat_events_unit verification clean");
        else
            $display("button_autorepeat_events_unit verification failed");
        $finish;
    end

endmodule
